FILE: src/dnsa_pkg.sv
// Package for the DNS response A-record extractor.
// Holds payload structs, parser phase and verdict types, and DNS constants.
// No dependencies.
package dnsa_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] expected_id;
  } dnsa_in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] ipv4_address;
  } dnsa_out_t;

  typedef enum logic [3:0] {
    PH_HEADER   = 4'd0,
    PH_NAME_LEN = 4'd1,
    PH_LABEL    = 4'd2,
    PH_PTR2     = 4'd3,
    PH_QTAIL    = 4'd4,
    PH_RR_HEAD  = 4'd5,
    PH_RR_SKIP  = 4'd6,
    PH_ADDR     = 4'd7,
    PH_DONE     = 4'd8
  } dnsa_phase_e;

  typedef enum logic [1:0] {
    V_PENDING = 2'd0,
    V_SUCCESS = 2'd1,
    V_FAIL    = 2'd2
  } dnsa_verdict_e;

  // step request from the input stage to the parser
  typedef struct packed {
    logic        step;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] expected_id;
  } dnsa_step_t;

  localparam logic [1:0]  PTR_TAG       = 2'b11;
  localparam logic [7:0]  TYPE_CLASS_HI = 8'h00;
  localparam logic [7:0]  TYPE_CLASS_LO = 8'h01;
  localparam logic [15:0] A_RDLENGTH    = 16'd4;
  localparam logic [15:0] HDR_ID_LO     = 16'd1;
  localparam logic [15:0] HDR_AN_HI     = 16'd6;
  localparam logic [15:0] HDR_AN_LO     = 16'd7;
  localparam logic [15:0] HDR_LAST      = 16'd11;
  localparam logic [15:0] QTAIL_LEN     = 16'd4;
  localparam logic [15:0] RR_TYPE_HI    = 16'd2;
  localparam logic [15:0] RR_TYPE_LO    = 16'd3;
  localparam logic [15:0] RR_CLASS_HI   = 16'd4;
  localparam logic [15:0] RR_CLASS_LO   = 16'd5;
  localparam logic [15:0] RR_RDLEN_HI   = 16'd10;
  localparam logic [15:0] RR_RDLEN_LO   = 16'd11;
  localparam logic [15:0] ADDR_LEN      = 16'd4;

endpackage

FILE: src/dnsa_parser.sv
// Byte-wise DNS response parser state and next-state logic.
// Depends on dnsa_pkg; driven one byte per cycle by the top level unless stalled.
module dnsa_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dnsa_pkg::dnsa_step_t step_i,
  output dnsa_pkg::dnsa_out_t  res_o
);
  import dnsa_pkg::*;

  dnsa_phase_e   phase_q, phase_d;
  dnsa_verdict_e verdict_q, verdict_d;
  logic [15:0]   cnt_q, cnt_d;
  logic [7:0]    hold_q, hold_d;
  logic [15:0]   answers_q, answers_d;
  logic          match_q, match_d;
  logic [31:0]   acc_q, acc_d;

  logic [7:0]    b;
  logic [15:0]   cnt_inc;
  logic [15:0]   cnt_dec;
  logic [15:0]   answers_dec;
  logic [15:0]   word;

  assign b           = step_i.data_byte;
  assign cnt_inc     = cnt_q + 16'd1;
  assign cnt_dec     = cnt_q - 16'd1;
  assign answers_dec = answers_q - 16'd1;
  assign word        = {hold_q, b};

  always_comb begin
    phase_d   = phase_q;
    verdict_d = verdict_q;
    cnt_d     = cnt_q;
    hold_d    = hold_q;
    answers_d = answers_q;
    match_d   = match_q;
    acc_d     = acc_q;
    if (verdict_q == V_PENDING) begin
      unique case (phase_q)
        PH_HEADER: begin
          cnt_d = cnt_inc;
          if (cnt_q == '0 || cnt_q == HDR_AN_HI) begin
            hold_d = b;
          end else if (cnt_q == HDR_ID_LO) begin
            if (word != step_i.expected_id) begin
              verdict_d = V_FAIL;
              phase_d   = PH_DONE;
            end
          end else if (cnt_q == HDR_AN_LO) begin
            answers_d = word;
          end
          if (cnt_q == HDR_LAST) begin
            phase_d = PH_NAME_LEN;
            cnt_d   = '0;
          end
        end
        PH_NAME_LEN: begin
          if (b == '0) begin
            phase_d = PH_QTAIL;
            cnt_d   = '0;
          end else if (b[7:6] == PTR_TAG) begin
            phase_d = PH_PTR2;
          end else begin
            phase_d = PH_LABEL;
            cnt_d   = {8'd0, b};
          end
        end
        PH_LABEL: begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            phase_d = PH_NAME_LEN;
          end
        end
        PH_PTR2: begin
          phase_d = PH_QTAIL;
          cnt_d   = '0;
        end
        PH_QTAIL: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= QTAIL_LEN) begin
            if (answers_q == '0) begin
              verdict_d = V_FAIL;
              phase_d   = PH_DONE;
            end else begin
              phase_d = PH_RR_HEAD;
              cnt_d   = '0;
              match_d = 1'b0;
            end
          end
        end
        PH_RR_HEAD: begin
          cnt_d = cnt_inc;
          if (cnt_q == RR_TYPE_HI) begin
            match_d = (b == TYPE_CLASS_HI);
          end else if (cnt_q == RR_TYPE_LO || cnt_q == RR_CLASS_LO) begin
            if (b != TYPE_CLASS_LO) match_d = 1'b0;
          end else if (cnt_q == RR_CLASS_HI) begin
            if (b != TYPE_CLASS_HI) match_d = 1'b0;
          end else if (cnt_q == RR_RDLEN_HI) begin
            hold_d = b;
          end
          if (cnt_q == RR_RDLEN_LO) begin
            if (match_q && word == A_RDLENGTH) begin
              phase_d = PH_ADDR;
              cnt_d   = '0;
              acc_d   = '0;
            end else if (word == '0) begin
              answers_d = answers_dec;
              if (answers_dec == '0) begin
                verdict_d = V_FAIL;
                phase_d   = PH_DONE;
              end else begin
                cnt_d   = '0;
                match_d = 1'b0;
              end
            end else begin
              phase_d = PH_RR_SKIP;
              cnt_d   = word;
            end
          end
        end
        PH_RR_SKIP: begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            answers_d = answers_dec;
            if (answers_dec == '0) begin
              verdict_d = V_FAIL;
              phase_d   = PH_DONE;
            end else begin
              phase_d = PH_RR_HEAD;
              match_d = 1'b0;
            end
          end
        end
        PH_ADDR: begin
          acc_d = {acc_q[23:0], b};
          cnt_d = cnt_inc;
          if (cnt_inc >= ADDR_LEN) begin
            verdict_d = V_SUCCESS;
            phase_d   = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_o.found        = (verdict_d == V_SUCCESS);
    res_o.ipv4_address = (verdict_d == V_SUCCESS) ? acc_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      verdict_q <= V_PENDING;
      cnt_q     <= '0;
      hold_q    <= '0;
      answers_q <= '0;
      match_q   <= 1'b0;
      acc_q     <= '0;
    end else if (step_i.step) begin
      if (step_i.last_byte) begin
        phase_q   <= PH_HEADER;
        verdict_q <= V_PENDING;
        cnt_q     <= '0;
        hold_q    <= '0;
        answers_q <= '0;
        match_q   <= 1'b0;
        acc_q     <= '0;
      end else begin
        phase_q   <= phase_d;
        verdict_q <= verdict_d;
        cnt_q     <= cnt_d;
        hold_q    <= hold_d;
        answers_q <= answers_d;
        match_q   <= match_d;
        acc_q     <= acc_d;
      end
    end
  end

  // a decided packet never goes back to pending before its last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.step && !step_i.last_byte && verdict_q != V_PENDING |=> verdict_q != V_PENDING)
    else $error("verdict left decided state mid-packet");

  // done phase and a decided verdict go together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) == (verdict_q != V_PENDING))
    else $error("phase and verdict disagree");

  // last byte returns the parser to the header phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.step && step_i.last_byte |=> phase_q == PH_HEADER && verdict_q == V_PENDING)
    else $error("parser not reset after last byte");

endmodule

FILE: src/dns_response_a_record_extractor.sv
// Top level of the DNS response A-record extractor: input and result registers.
// Depends on dnsa_pkg and dnsa_parser.
// Takes one packet byte per cycle on the input channel; a transaction is one
// byte with its last-byte mark and the expected id. Each byte goes through an
// input register and is parsed from it when it advances. Only the last byte of a
// packet produces one result transaction (found plus address, zero address on
// failure); the result register is loaded from the parser when that registered
// last byte advances. The input keeps taking a byte every cycle; it stalls only
// while a registered last byte waits because the previous result has not yet
// been taken from the result register.
module dns_response_a_record_extractor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dnsa_pkg::dnsa_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dnsa_pkg::dnsa_out_t out_data_o
);
  import dnsa_pkg::*;

  logic       in_valid_q;
  dnsa_in_t   in_data_q;
  logic       out_valid_q;
  dnsa_out_t  out_data_q;
  logic       advance;
  dnsa_step_t step;
  dnsa_out_t  res;

  assign advance    = in_valid_q && !(in_data_q.last_byte && out_valid_q && !out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    step.step        = advance;
    step.data_byte   = in_data_q.data_byte;
    step.last_byte   = in_data_q.last_byte;
    step.expected_id = in_data_q.expected_id;
  end

  dnsa_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_data_q.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_data_q.last_byte) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // failure always carries a zero address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.ipv4_address == '0)
    else $error("nonzero address on failure");

  // input stalls only behind a waiting last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && in_data_q.last_byte && out_valid_q && !out_ready_i)
    else $error("unexpected input stall");

  // a processed last byte always yields a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_data_q.last_byte |=> out_valid_o)
    else $error("result lost for last byte");

endmodule
